// ===== design/sdis_pkg.sv =====
// Shared types and constants for the sorted dual integer set engine.
// Used by sdis_cell, sdis_chain and sorted_dual_int_set_engine; no other dependencies.
package sdis_pkg;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_LIST   = 3'd2;
  localparam logic [2:0] OP_UNION  = 3'd3;
  localparam logic [2:0] OP_INTER  = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic               which_set;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic               last;
    logic               empty_res;
    logic [1:0]         status;
  } res_t;

  // Per-cell control from the sequencer, shared by every cell of one set.
  typedef struct packed {
    logic        ins;    // insert: value into pos, cells above pos take left neighbor
    logic        del;    // delete: cells at or above pos take right neighbor
    logic        shl;    // rotate toward index 0 (read-out walk)
    logic [5:0]  pos;
    logic [31:0] value;
  } cell_ctl_t;

endpackage

// ===== design/sdis_cell.sv =====
// One storage cell of a set chain: holds a word, shifts with its neighbors.
// Depends on sdis_pkg.
module sdis_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic              clk_i,
  input  sdis_pkg::cell_ctl_t ctl_i,
  input  logic [31:0]       left_i,
  input  logic [31:0]       right_i,
  output logic [31:0]       word_o
);
  logic [31:0] word_q, word_d;
  logic        at_pos, above;

  assign at_pos = (ctl_i.pos == 6'(Idx));
  assign above  = (6'(Idx) > ctl_i.pos);

  always_comb begin
    word_d = word_q;
    if (ctl_i.shl) begin
      word_d = right_i;
    end else if (ctl_i.ins) begin
      if (at_pos) word_d = ctl_i.value;
      else if (above) word_d = left_i;
    end else if (ctl_i.del) begin
      if (at_pos || above) word_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
endmodule

// ===== design/sdis_chain.sv =====
// A chain of Depth cells holding one sorted set; head is cell 0.
// Depends on sdis_pkg and sdis_cell.
module sdis_chain #(
  parameter int unsigned Depth = 32
) (
  input  logic                clk_i,
  input  sdis_pkg::cell_ctl_t ctl_i,
  output logic [Depth*32-1:0] words_o
);
  logic [31:0] w [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [31:0] lft, rgt;
    if (k == 0) begin : g_l0
      assign lft = ctl_i.value;
    end else begin : g_l
      assign lft = w[k-1];
    end
    // rotate wraps head to tail, so a read-out walk restores order
    if (k == Depth - 1) begin : g_rt
      assign rgt = ctl_i.shl ? w[0] : w[k];
    end else begin : g_r
      assign rgt = w[k+1];
    end
    sdis_cell #(.Idx(k)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .left_i (lft),
      .right_i(rgt),
      .word_o (w[k])
    );
    assign words_o[k*32 +: 32] = w[k];
  end
endmodule

// ===== design/sorted_dual_int_set_engine.sv =====
// Top level of the sorted dual integer set engine: sequencer plus two chains.
// Depends on sdis_pkg, sdis_chain, sdis_cell.
//
// Usage: raise start with cmd_i while busy is low; the command is taken
// at that edge. Results come out on res_o, one per cycle while res_valid_o
// is high; the receiver always takes them and cannot stall the block.
// Add and remove give one status beat. List, union and intersection stream
// the answer ascending, last set on the final beat; an empty answer is one
// beat with empty_res set. Unused op codes give no beat.
// Operation: add and remove first compare all cells against the value
// (per-cell compare, S_FIND), then shift the chain (S_MOD); the status
// beat is registered in S_MOD and driven in the same cycle that busy
// drops, so the next command can be taken while that beat is out.
// Queries rotate the chains through their head cells, one step per cycle,
// until neither head is taken, which closes the walk; every chain that was
// rotated then keeps rotating until it has turned SET_DEPTH steps in all,
// and then the sequencer returns to idle.
// Reset clears both counts and the sequencer; store contents need no reset.
module sorted_dual_int_set_engine #(
  parameter int unsigned SET_DEPTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  sdis_pkg::cmd_t cmd_i,
  output logic          busy,
  output logic          res_valid_o,
  output sdis_pkg::res_t res_o
);
  typedef enum logic [2:0] {S_IDLE, S_FIND, S_MOD, S_WALK, S_FLUSH} state_e;

  localparam logic [5:0] DepthW = 6'(SET_DEPTH);

  state_e      state_q;
  sdis_pkg::cmd_t cmd_q;
  logic [5:0]  cnt_x_q, cnt_y_q;
  logic [5:0]  ix_q, iy_q;   // consumed per chain during the walk
  logic [5:0]  px_q, py_q;   // total rotate steps done per chain
  logic [5:0]  pos_q;
  logic [1:0]  stat_q;
  logic        emitted_q;
  logic signed [31:0] hold_q;
  logic        res_valid_q;
  sdis_pkg::res_t res_q;

  sdis_pkg::cell_ctl_t ctl_x, ctl_y;
  logic [SET_DEPTH*32-1:0] wx, wy;

  sdis_chain #(.Depth(SET_DEPTH)) u_x (.clk_i(clk_i), .ctl_i(ctl_x), .words_o(wx));
  sdis_chain #(.Depth(SET_DEPTH)) u_y (.clk_i(clk_i), .ctl_i(ctl_y), .words_o(wy));

  // target chain view
  logic [SET_DEPTH*32-1:0] wt;
  logic [5:0] cnt_t;
  assign wt    = cmd_q.which_set ? wy : wx;
  assign cnt_t = cmd_q.which_set ? cnt_y_q : cnt_x_q;

  // per-cell compare: position = number of valid elements below value;
  // the set is sorted, so the below flags form one run from cell 0
  logic [5:0] lt_pos;
  logic       eq_any;
  logic [5:0] eq_pos;
  always_comb begin
    lt_pos = '0;
    eq_any = 1'b0;
    eq_pos = '0;
    for (int k = 0; k < SET_DEPTH; k++) begin
      if (6'(k) < cnt_t) begin
        if ($signed(wt[k*32 +: 32]) < cmd_q.value) lt_pos = 6'(k + 1);
        if (wt[k*32 +: 32] == cmd_q.value) begin
          eq_any = 1'b1;
          eq_pos = 6'(k);
        end
      end
    end
  end

  // heads during a walk
  logic signed [31:0] hx, hy;
  logic hx_ok, hy_ok, x_lt, y_lt;
  assign hx = wx[31:0];
  assign hy = wy[31:0];
  assign hx_ok = ix_q < cnt_x_q;
  assign hy_ok = iy_q < cnt_y_q;
  assign x_lt = hx < hy;
  assign y_lt = hy < hx;

  // walk decision
  logic take_x, take_y, emit;
  logic signed [31:0] emit_val;
  logic walk_end;
  always_comb begin
    take_x = 1'b0; take_y = 1'b0; emit = 1'b0; emit_val = hx;
    case (cmd_q.op)
      sdis_pkg::OP_LIST: begin
        if (cmd_q.which_set) begin
          take_y = hy_ok; emit = hy_ok; emit_val = hy;
        end else begin
          take_x = hx_ok; emit = hx_ok;
        end
      end
      sdis_pkg::OP_UNION: begin
        if (hx_ok && (!hy_ok || x_lt)) begin
          take_x = 1'b1; emit = 1'b1;
        end else if (hy_ok && (!hx_ok || y_lt)) begin
          take_y = 1'b1; emit = 1'b1; emit_val = hy;
        end else if (hx_ok) begin
          take_x = 1'b1; take_y = 1'b1; emit = 1'b1;
        end
      end
      default: begin
        if (hx_ok && hy_ok) begin
          if (x_lt) take_x = 1'b1;
          else if (y_lt) take_y = 1'b1;
          else begin
            take_x = 1'b1; take_y = 1'b1; emit = 1'b1;
          end
        end
      end
    endcase
    walk_end = !take_x && !take_y;
  end

  // flush: a rotated chain turns until SET_DEPTH steps in all, which puts
  // the smallest element back in cell 0
  logic fx, fy;
  assign fx = (px_q != 6'd0) && (px_q < DepthW);
  assign fy = (py_q != 6'd0) && (py_q < DepthW);

  always_comb begin
    ctl_x = '0;
    ctl_y = '0;
    ctl_x.value = cmd_q.value;
    ctl_y.value = cmd_q.value;
    ctl_x.pos = pos_q;
    ctl_y.pos = pos_q;
    case (state_q)
      S_MOD: begin
        if (stat_q == sdis_pkg::ST_DONE) begin
          if (cmd_q.which_set) begin
            ctl_y.ins = (cmd_q.op == sdis_pkg::OP_ADD);
            ctl_y.del = (cmd_q.op == sdis_pkg::OP_REMOVE);
          end else begin
            ctl_x.ins = (cmd_q.op == sdis_pkg::OP_ADD);
            ctl_x.del = (cmd_q.op == sdis_pkg::OP_REMOVE);
          end
        end
      end
      S_WALK: begin
        ctl_x.shl = take_x;
        ctl_y.shl = take_y;
      end
      S_FLUSH: begin
        ctl_x.shl = fx;
        ctl_y.shl = fy;
      end
      default: ;
    endcase
  end

  logic walk_beat;
  assign walk_beat = (emit && emitted_q) || walk_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_x_q     <= '0;
      cnt_y_q     <= '0;
      ix_q        <= '0;
      iy_q        <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pos_q       <= '0;
      stat_q      <= sdis_pkg::ST_DONE;
      emitted_q   <= 1'b0;
      hold_q      <= '0;
      res_valid_q <= 1'b0;
      cmd_q       <= '0;
      res_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          res_valid_q <= 1'b0;
          if (start) begin
            cmd_q     <= cmd_i;
            ix_q      <= '0;
            iy_q      <= '0;
            px_q      <= '0;
            py_q      <= '0;
            emitted_q <= 1'b0;
            case (cmd_i.op)
              sdis_pkg::OP_ADD, sdis_pkg::OP_REMOVE: state_q <= S_FIND;
              sdis_pkg::OP_LIST, sdis_pkg::OP_UNION, sdis_pkg::OP_INTER:
                state_q <= S_WALK;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_FIND: begin
          res_valid_q <= 1'b0;
          if (cmd_q.op == sdis_pkg::OP_ADD) begin
            pos_q <= lt_pos;
            if (eq_any) stat_q <= sdis_pkg::ST_PRESENT;
            else if (cnt_t >= DepthW) stat_q <= sdis_pkg::ST_FULL;
            else stat_q <= sdis_pkg::ST_DONE;
          end else begin
            pos_q  <= eq_pos;
            stat_q <= eq_any ? sdis_pkg::ST_DONE : sdis_pkg::ST_MISSING;
          end
          state_q <= S_MOD;
        end
        S_MOD: begin
          if (stat_q == sdis_pkg::ST_DONE) begin
            if (cmd_q.which_set) begin
              cnt_y_q <= (cmd_q.op == sdis_pkg::OP_ADD) ? cnt_y_q + 6'd1 : cnt_y_q - 6'd1;
            end else begin
              cnt_x_q <= (cmd_q.op == sdis_pkg::OP_ADD) ? cnt_x_q + 6'd1 : cnt_x_q - 6'd1;
            end
          end
          res_valid_q       <= 1'b1;
          res_q.element     <= '0;
          res_q.last        <= 1'b1;
          res_q.empty_res   <= 1'b0;
          res_q.status      <= stat_q;
          state_q           <= S_IDLE;
        end
        S_WALK: begin
          if (take_x) begin
            ix_q <= ix_q + 6'd1;
            px_q <= px_q + 6'd1;
          end
          if (take_y) begin
            iy_q <= iy_q + 6'd1;
            py_q <= py_q + 6'd1;
          end
          // one beat behind: hold the element and send it when the next
          // is known, so last can be set on the final one
          if (emit) begin
            hold_q    <= emit_val;
            emitted_q <= 1'b1;
          end
          res_valid_q <= walk_beat;
          if (walk_beat) begin
            res_q.element   <= emitted_q ? hold_q : '0;
            res_q.last      <= walk_end;
            res_q.empty_res <= !emitted_q;
            res_q.status    <= sdis_pkg::ST_DONE;
          end
          if (walk_end) state_q <= S_FLUSH;
        end
        S_FLUSH: begin
          res_valid_q <= 1'b0;
          if (fx) px_q <= px_q + 6'd1;
          if (fy) py_q <= py_q + 6'd1;
          if (!fx && !fy) state_q <= S_IDLE;
        end
        default: begin
          res_valid_q <= 1'b0;
          state_q     <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef ASSERT_OFF
  a_cnt_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x_q <= DepthW) else $error("x count above depth");
  a_cnt_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_y_q <= DepthW) else $error("y count above depth");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !res_valid_q || $past(state_q) != S_IDLE)
    else $error("result beat from idle");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (ix_q <= cnt_x_q) && (iy_q <= cnt_y_q))
    else $error("walk past count");
`endif
endmodule
